/* rtl/core/text_mode_console_writer_top_defines.svh */
// Assertion macros for the text-mode console writer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under the asynchronous reset.
`define TMCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console writer check failed");
// Next-cycle implication under the asynchronous reset.
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console writer check failed");
`else
`define TMCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/tmcw_pkg.sv */
// Shared constants and helpers for the text-mode console writer.
// No dependencies; used by the screen store and the top level.
package tmcw_pkg;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Field widths
	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int CELL_W     = 16;
	localparam int COLOR_W    = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Colors
	localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h0F;
	localparam logic [COLOR_W-1:0] WHITE_ON_BLACK = 8'h0F;

	function automatic logic [CELL_W-1:0] make_cell(
		input logic [CHAR_W-1:0]  ch,
		input logic [COLOR_W-1:0] color
	);
		make_cell = {color, ch};
	endfunction

	localparam logic [CELL_W-1:0] BLANK_CELL = {WHITE_ON_BLACK, CH_SPACE};

endpackage

/* rtl/core/tmcw_screen.sv */
// Screen cell store: one write port, one read port with registered data.
// Depends on tmcw_pkg for the cell width.
module tmcw_screen #(
	parameter int DEPTH = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tmcw_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [tmcw_pkg::CELL_W-1:0] rdata
);

	logic [tmcw_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tmcw_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/text_mode_console_writer_top.sv */
// Text-mode console writer: sequencer, cursor state and result register.
// Depends on tmcw_pkg, tmcw_screen and text_mode_console_writer_top_defines.svh.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  s_axis   | in        | s_tvalid / s_tready | s_tdata: operation, character, index
//  m_axis   | out       | m_tvalid / m_tready | m_tdata: row, column, scrolled, cell
//  cfg      | in        | cfg_valid/cfg_ready | cfg_data: text color
//
// A put without scroll, or an unused operation code, loads the result register
// in the accept cycle; a read first passes ST_READ for the registered store read.
// A clear or a scrolling put runs a sweep after acceptance: the sweep counter
// walks the store, one cell a cycle through its single write port, then ST_FLUSH
// drains the last write. After reset a clearing pass blanks the store;
// no item is accepted during it, configuration writes are taken always.
// A stalled result holds m_tdata; a new item is taken once the result slot
// is empty or drains in the same cycle.
`include "text_mode_console_writer_top_defines.svh"

module text_mode_console_writer_top #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// fields from bit 0: operation[1:0], character[9:2], cell_index[20:10]
	input  logic [tmcw_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: cursor_row[4:0], cursor_column[11:5], scrolled[12],
	// cell_value[28:13]
	output logic [tmcw_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [tmcw_pkg::COLOR_W-1:0]    cfg_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready
);

	localparam int N      = ROWS * COLUMNS;
	localparam int AW     = $clog2(N);
	localparam int RW     = $clog2(ROWS);
	localparam int CLW    = $clog2(COLUMNS);
	localparam int COPY_N = (ROWS - 1) * COLUMNS;
	localparam int XW     = (AW > tmcw_pkg::INDEX_W) ? AW : tmcw_pkg::INDEX_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FILL   = 6'b000010,
		ST_SCROLL = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_READ   = 6'b010000,
		ST_SPARE  = 6'b100000
	} state_t;

	state_t state_q;

	// Sweep counter and one-deep pending write (lets a copy wait for read data)
	logic [AW-1:0]               scan_q;
	logic                        pend_q;
	logic                        pend_copy_q;
	logic [AW-1:0]               pend_addr_q;
	logic [tmcw_pkg::CELL_W-1:0] fill_data_q;
	logic                        emit_q;
	logic                        scroll_q;
	logic                        in_range_q;

	// Cursor: line base tracks row*COLUMNS so no multiply is needed
	logic [RW-1:0]  row_q, row_nxt;
	logic [CLW-1:0] col_q, col_nxt;
	logic [AW-1:0]  line_base_q, line_base_nxt;

	logic [tmcw_pkg::COLOR_W-1:0]    color_q;
	logic                            out_valid_q;
	logic [tmcw_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [tmcw_pkg::OP_W-1:0]    op_in;
	logic [tmcw_pkg::CHAR_W-1:0]  ch_in;
	logic [tmcw_pkg::INDEX_W-1:0] idx_in;
	logic [XW-1:0]                idx_ext;
	logic                         idx_in_range;
	logic                         in_acc;

	logic                        put_we;
	logic [AW-1:0]               put_addr;
	logic [tmcw_pkg::CELL_W-1:0] put_data;
	logic                        adv_row;
	logic                        start_scroll;
	logic                        res_now;
	logic                        res_load;
	logic                        res_scrolled;
	logic [tmcw_pkg::CELL_W-1:0] res_cell;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tmcw_pkg::CELL_W-1:0] mem_wdata;
	logic [AW-1:0]               mem_raddr;
	logic [tmcw_pkg::CELL_W-1:0] mem_rdata;

	// Unpack the input transfer
	assign op_in   = s_tdata[1:0];
	assign ch_in   = s_tdata[9:2];
	assign idx_in  = s_tdata[20:10];
	assign idx_ext = XW'(idx_in);
	assign idx_in_range = (idx_ext < XW'(N));

	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Put decode and cursor update for the accept cycle
	always_comb begin
		row_nxt       = row_q;
		col_nxt       = col_q;
		line_base_nxt = line_base_q;
		put_we        = 1'b0;
		put_addr      = line_base_q + AW'(col_q);
		put_data      = tmcw_pkg::make_cell(ch_in, color_q);
		adv_row       = 1'b0;
		start_scroll  = 1'b0;
		res_now       = 1'b0;
		if (in_acc) begin
			case (op_in)
				tmcw_pkg::OP_PUT: begin
					res_now = 1'b1;
					if (ch_in == tmcw_pkg::CH_BACKSPACE && col_q != '0) begin
						col_nxt  = col_q - CLW'(1);
						put_we   = 1'b1;
						put_addr = line_base_q + AW'(col_q - CLW'(1));
						put_data = tmcw_pkg::BLANK_CELL;
					end else if (ch_in == tmcw_pkg::CH_NEWLINE) begin
						col_nxt = '0;
						adv_row = 1'b1;
					end else if (ch_in == tmcw_pkg::CH_RETURN) begin
						col_nxt = '0;
					end else if (!ch_in[7] && ch_in >= tmcw_pkg::CH_SPACE) begin
						put_we = 1'b1;
						if (col_q == CLW'(COLUMNS - 1)) begin
							col_nxt = '0;
							adv_row = 1'b1;
						end else begin
							col_nxt = col_q + CLW'(1);
						end
					end
					if (adv_row) begin
						if (row_q == RW'(ROWS - 1)) begin
							// Stay on the bottom row; the sweep shifts the screen
							start_scroll = 1'b1;
							res_now      = 1'b0;
						end else begin
							row_nxt       = row_q + RW'(1);
							line_base_nxt = line_base_q + AW'(COLUMNS);
						end
					end
				end
				tmcw_pkg::OP_CLEAR: begin
					row_nxt       = '0;
					col_nxt       = '0;
					line_base_nxt = '0;
				end
				tmcw_pkg::OP_READ: begin
					res_now = 1'b0;
				end
				default: begin
					res_now = 1'b1;
				end
			endcase
		end
	end

	// Result assembly
	assign res_load     = res_now || (state_q == ST_READ) || (state_q == ST_FLUSH && emit_q);
	assign res_scrolled = (state_q == ST_FLUSH) && scroll_q;
	assign res_cell     = (state_q == ST_READ && in_range_q) ? mem_rdata : '0;

	// Store ports: pending sweep writes take the port, else a put write
	assign mem_we    = pend_q || put_we;
	assign mem_waddr = pend_q ? pend_addr_q : put_addr;
	assign mem_wdata = pend_q ? (pend_copy_q ? mem_rdata : fill_data_q) : put_data;
	assign mem_raddr = (state_q == ST_IDLE) ? idx_ext[AW-1:0] : scan_q + AW'(COLUMNS);

	tmcw_screen #(
		.DEPTH (N),
		.AW    (AW)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			pend_copy_q <= 1'b0;
			pend_addr_q <= '0;
			fill_data_q <= tmcw_pkg::BLANK_CELL;
			emit_q      <= 1'b0;
			scroll_q    <= 1'b0;
			in_range_q  <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op_in == tmcw_pkg::OP_CLEAR) begin
							state_q     <= ST_FILL;
							scan_q      <= '0;
							fill_data_q <= tmcw_pkg::make_cell(tmcw_pkg::CH_SPACE, color_q);
							emit_q      <= 1'b1;
							scroll_q    <= 1'b0;
						end else if (op_in == tmcw_pkg::OP_READ) begin
							state_q    <= ST_READ;
							in_range_q <= idx_in_range;
						end else if (start_scroll) begin
							state_q  <= ST_SCROLL;
							scan_q   <= '0;
							emit_q   <= 1'b1;
							scroll_q <= 1'b1;
						end
					end
				end
				ST_SCROLL: begin
					// Copy cell scan+COLUMNS down to scan once its read data lands
					pend_q      <= 1'b1;
					pend_copy_q <= 1'b1;
					pend_addr_q <= scan_q;
					scan_q      <= scan_q + AW'(1);
					if (scan_q == AW'(COPY_N - 1)) begin
						state_q     <= ST_FILL;
						fill_data_q <= tmcw_pkg::make_cell(tmcw_pkg::CH_SPACE, color_q);
					end
				end
				ST_FILL: begin
					pend_q      <= 1'b1;
					pend_copy_q <= 1'b0;
					pend_addr_q <= scan_q;
					if (scan_q == AW'(N - 1)) begin
						state_q <= ST_FLUSH;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Cursor, color and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			line_base_q <= '0;
			color_q     <= tmcw_pkg::COLOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			row_q       <= row_nxt;
			col_q       <= col_nxt;
			line_base_q <= line_base_nxt;
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= tmcw_pkg::OUT_DATA_W'({res_cell, res_scrolled,
				tmcw_pkg::COL_OUT_W'(col_nxt), tmcw_pkg::ROW_OUT_W'(row_nxt)});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	`TMCW_ASSERT_IMPLY(a_pend_not_idle, clk, arst_n, pend_q, state_q != ST_IDLE)
	`TMCW_ASSERT_IMPLY(a_col_bound, clk, arst_n, 1'b1, col_q < CLW'(COLUMNS - 1) || col_q == CLW'(COLUMNS - 1))
	`TMCW_ASSERT_IMPLY(a_line_base, clk, arst_n, 1'b1, line_base_q == AW'(row_q * COLUMNS))
	`TMCW_ASSERT_NEXT(a_clear_home, clk, arst_n, in_acc && op_in == tmcw_pkg::OP_CLEAR, row_q == '0 && col_q == '0 && state_q == ST_FILL)

endmodule
